/* hw/rtl/bse_pkg.sv */
// Shared types and constants of the border state expander.
// Holds the transaction structs, the cell type codes and the state flag masks.
// No dependencies.
`default_nettype none

package bse_pkg;

  // Sizes
  localparam int unsigned MaxWidthDef = 21;
  localparam int unsigned StateW      = 64;
  localparam int unsigned CountW      = 64;
  localparam int unsigned PosW        = 5;
  localparam int unsigned MaskW       = 16;
  localparam int unsigned TypeW       = 4;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 5;
  localparam int unsigned NumCand     = 11;
  localparam int unsigned StkShift    = 7;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBumpPos   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBorderLen = 2'd1;

  // Cell type codes and type bits
  localparam logic [TypeW-1:0] TEdge  = 4'd0;
  localparam logic [TypeW-1:0] TEmpty = 4'd1;
  localparam logic [TypeW-1:0] TLib   = 4'd2;
  localparam logic [TypeW-1:0] TColor = 4'd1;
  localparam logic [TypeW-1:0] TNeedy = 4'd8;
  localparam logic [TypeW-1:0] THasR  = 4'd4;
  localparam logic [TypeW-1:0] THasL  = 4'd2;

  // State flag masks
  localparam logic [StateW-1:0] FNorm    = 64'h10;
  localparam logic [StateW-1:0] FNdyBump = 64'h20;
  localparam logic [StateW-1:0] FSetEdge = 64'h40;
  localparam logic [StateW-1:0] StkMask  = ~64'h7f;

  typedef struct packed {
    logic [StateW-1:0] current_state;
    logic [CountW-1:0] path_count;
    logic [PosW-1:0]   position;
    logic [MaskW-1:0]  allow_mask;
  } in_item_t;

  typedef struct packed {
    logic [StateW-1:0] next_state;
    logic [CountW-1:0] next_count;
    logic              last;
  } out_item_t;

  // Decoded fields of one input state
  typedef struct packed {
    logic [StateW-1:0] stack;
    logic [TypeW-1:0]  prev;
    logic              norm;
    logic              ndy;
    logic              before_bump;
    logic              at_bump;
    logic              pos_zero;
    logic [StateW-1:0] hi_mask;
    logic [MaskW-1:0]  allow;
    logic [CountW-1:0] count;
  } dec_t;

  // All candidate successors of one input with their keep bits
  typedef struct packed {
    logic [NumCand-1:0][StateW-1:0] cand;
    logic [NumCand-1:0]             keep;
    logic [CountW-1:0]              count;
  } cset_t;

endpackage

`default_nettype wire

/* hw/rtl/border_state_expander.sv */
// Border state expander: expands one packed border state into its kept
// successor states for one column of a transfer-matrix border count.
//
// Input: an item is taken at a clock edge with start high and busy low.
// Results leave on result_o, one per cycle, each marked by valid_o for one
// cycle; result_o.last flags the final successor of an item. An item with no
// kept successor produces nothing. The receiver cannot hold results off.
// Configuration: cfg_valid_i with cfg_index_i selects bump position (0) or
// border length (1); cfg_ready_o is always high. Writes take effect on the
// next item and belong in idle periods.
// Path: an item passes the decode stage, the expand stage, the serializer load
// and the result register before its first result leaves.
// Rate: the serializer takes a new candidate set only while it sends the last
// successor of the previous set or holds none, so the single result port sets
// the rate; an item has at most nine kept successors.
// busy goes high once both pipeline stages hold items that cannot advance.
// Reset clears the pipeline and sets bump position 0, border length MaxWidth.
`default_nettype none

module border_state_expander #(
  parameter int unsigned MaxWidth = bse_pkg::MaxWidthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire bse_pkg::in_item_t               item_i,
  output logic                                 valid_o,
  output bse_pkg::out_item_t                   result_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bse_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [bse_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  localparam int unsigned BlW = $clog2(MaxWidth + 1);

  logic [bse_pkg::PosW-1:0] bump_q, bump_d;
  logic [BlW-1:0]           bl_q, bl_d;
  logic                     dec_rdy, dec_v, exp_rdy, exp_v, ser_rdy;
  bse_pkg::dec_t            dec;
  bse_pkg::cset_t           cset;

  assign cfg_ready_o = 1'b1;

  // Decode configuration writes; saturate the border length
  always_comb begin
    bump_d = bump_q;
    bl_d   = bl_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bse_pkg::CfgBumpPos: bump_d = cfg_wdata_i;
        bse_pkg::CfgBorderLen: begin
          if (32'(cfg_wdata_i) > MaxWidth) begin
            bl_d = BlW'(MaxWidth);
          end else begin
            bl_d = BlW'(cfg_wdata_i);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q <= '0;
      bl_q   <= BlW'(MaxWidth);
    end else begin
      bump_q <= bump_d;
      bl_q   <= bl_d;
    end
  end

  assign busy = !dec_rdy;

  bse_decode #(
    .BlW (BlW)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start),
    .item_i       (item_i),
    .bump_pos_i   (bump_q),
    .border_len_i (bl_q),
    .ready_o      (dec_rdy),
    .valid_o      (dec_v),
    .dec_o        (dec),
    .ready_i      (exp_rdy)
  );

  bse_expand u_expand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_v),
    .dec_i   (dec),
    .ready_o (exp_rdy),
    .valid_o (exp_v),
    .set_o   (cset),
    .ready_i (ser_rdy)
  );

  bse_serialize u_serialize (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (exp_v),
    .set_i    (cset),
    .ready_o  (ser_rdy),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  // Successors of one transaction leave in consecutive cycles
  a_burst_contiguous : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_o.last |=> valid_o)
    else $error("result burst broken before last");

  // A serializer holding more than one pending successor emits next cycle
  a_pending_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ser_rdy |=> valid_o)
    else $error("pending successors not emitted");

  // Border length never exceeds the configured maximum
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i == bse_pkg::CfgBorderLen) |=> 32'(bl_q) <= MaxWidth)
    else $error("border length above maximum");

endmodule

`default_nettype wire

/* hw/rtl/bse_decode.sv */
// Stage one of the expander: splits the packed state into type, flags and stack,
// compares the column against the bump and builds the stack fit mask.
// Depends on bse_pkg.
`default_nettype none

module bse_decode #(
  parameter int unsigned BlW = 5
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire bse_pkg::in_item_t            item_i,
  input  wire logic [bse_pkg::PosW-1:0]     bump_pos_i,
  input  wire logic [BlW-1:0]               border_len_i,
  output logic                              ready_o,
  output logic                              valid_o,
  output bse_pkg::dec_t                     dec_o,
  input  wire logic                         ready_i
);

  logic          v_q;
  bse_pkg::dec_t dec_d, dec_q;
  logic [6:0]    lim_sum;
  logic [6:0]    pos_ext;
  logic [6:0]    shift_amt;

  assign ready_o = !v_q || ready_i;

  // Decode the state fields and the fit limit
  always_comb begin
    dec_d.prev  = item_i.current_state[6] ? bse_pkg::TEdge
                                          : item_i.current_state[3:0];
    dec_d.norm  = item_i.current_state[4];
    dec_d.ndy   = item_i.current_state[5];
    dec_d.stack = item_i.current_state & bse_pkg::StkMask;
    dec_d.before_bump = (bump_pos_i != '0) &&
                        (item_i.position == bump_pos_i - bse_pkg::PosW'(1));
    dec_d.at_bump  = item_i.position == bump_pos_i;
    dec_d.pos_zero = item_i.position == '0;
    dec_d.allow    = item_i.allow_mask;
    dec_d.count    = item_i.path_count;
    // Keep only states that are zero at and above bit 7 + length - position
    lim_sum   = 7'(bse_pkg::StkShift) + 7'(border_len_i);
    pos_ext   = 7'(item_i.position);
    shift_amt = lim_sum - pos_ext;
    if (lim_sum <= pos_ext) begin
      dec_d.hi_mask = '1;
    end else begin
      dec_d.hi_mask = {bse_pkg::StateW{1'b1}} << shift_amt[5:0];
    end
  end

  // Advance when the next stage is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = v_q;
  assign dec_o   = dec_q;

endmodule

`default_nettype wire

/* hw/rtl/bse_expand.sv */
// Stage two of the expander: builds all candidate successors of one state
// and tests each against the allow mask and the stack fit mask.
// Depends on bse_pkg.
`default_nettype none

module bse_expand (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire bse_pkg::dec_t   dec_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output bse_pkg::cset_t       set_o,
  input  wire logic            ready_i
);

  logic                              v_q;
  bse_pkg::cset_t                    set_d, set_q;
  logic [bse_pkg::NumCand-1:0]       en;
  logic [1:0]                        lib_en, ndy_en, cls_en;
  logic [bse_pkg::StateW-1:0]        norm_f, ndy_f, se0, se_cl;
  logic [bse_pkg::StateW-1:0]        lib_se, ndy_c, znorm, se_n;
  logic [bse_pkg::TypeW-1:0]         cb;

  assign ready_o = !v_q || ready_i;

  // Decide which moves are legal for each color
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      lib_en[c] = !dec_i.prev[3] || (dec_i.prev[0] != 1'(c));
      ndy_en[c] = !(dec_i.at_bump && (c == 0)) &&
                  ((dec_i.prev == bse_pkg::TEdge) ||
                   ((dec_i.prev != bse_pkg::TEmpty) && (dec_i.prev[0] != 1'(c))));
      cls_en[c] = !(dec_i.at_bump && (c == 0)) &&
                  (|dec_i.stack[bse_pkg::StateW-1:8]) &&
                  (dec_i.stack[bse_pkg::StkShift] == 1'(c)) &&
                  !((dec_i.prev == bse_pkg::TEmpty) ||
                    (dec_i.prev == (bse_pkg::TLib | 4'(c))) ||
                    ((dec_i.prev & (bse_pkg::TNeedy | bse_pkg::THasR | bse_pkg::TColor))
                      == (bse_pkg::TNeedy | 4'(c))));
    end
  end

  // Build the candidates in emission order
  always_comb begin
    norm_f = dec_i.norm ? bse_pkg::FNorm : '0;
    ndy_f  = dec_i.ndy ? bse_pkg::FNdyBump : '0;
    se0    = dec_i.before_bump ? bse_pkg::FSetEdge : '0;
    se_cl  = (dec_i.before_bump &&
              ((dec_i.prev & (bse_pkg::TNeedy | bse_pkg::THasR))
                == (bse_pkg::TNeedy | bse_pkg::THasR))) ? bse_pkg::FSetEdge : '0;
    lib_se = '0;
    ndy_c  = '0;
    znorm  = '0;
    se_n   = '0;
    cb     = '0;

    set_d.cand[0] = dec_i.stack | se0 | ndy_f | norm_f | 64'(bse_pkg::TEmpty);
    en[0]         = !dec_i.prev[3];

    for (int c = 0; c < 2; c++) begin
      cb     = 4'(c);
      lib_se = (dec_i.before_bump && ((dec_i.prev == bse_pkg::TEmpty) ||
                (dec_i.prev == (bse_pkg::TLib | cb)))) ? bse_pkg::FSetEdge : '0;
      ndy_c  = ((c == 1) && dec_i.at_bump) ? bse_pkg::FNdyBump : ndy_f;
      znorm  = dec_i.pos_zero ? ((c == 1) ? bse_pkg::FNorm : '0) : norm_f;
      // the white needy pair keeps the edge flag chosen by the black closing pair
      se_n   = ((c == 1) && cls_en[0]) ? se_cl : se0;

      set_d.cand[1 + 5*c] = dec_i.stack | ndy_f | ((c == 0) ? bse_pkg::FNorm : '0) |
                            64'(bse_pkg::TLib | cb) | lib_se;
      set_d.cand[2 + 5*c] = dec_i.stack | se_n | ndy_c | znorm |
                            64'(bse_pkg::TNeedy | cb);
      set_d.cand[3 + 5*c] = (dec_i.stack << 1) | (64'(cb) << bse_pkg::StkShift) |
                            ndy_c | znorm |
                            64'(bse_pkg::TNeedy | bse_pkg::THasR | cb);
      set_d.cand[4 + 5*c] = dec_i.stack | se_cl | ndy_c | norm_f |
                            64'(bse_pkg::TNeedy | bse_pkg::THasL | bse_pkg::THasR | cb);
      set_d.cand[5 + 5*c] = ((dec_i.stack >> 1) & bse_pkg::StkMask) | se_cl | ndy_c |
                            norm_f | 64'(bse_pkg::TNeedy | bse_pkg::THasL | cb);

      en[1 + 5*c] = lib_en[c];
      en[2 + 5*c] = ndy_en[c];
      en[3 + 5*c] = ndy_en[c];
      en[4 + 5*c] = cls_en[c];
      en[5 + 5*c] = cls_en[c];
    end

    // Filter by allowed type and stack fit
    for (int i = 0; i < int'(bse_pkg::NumCand); i++) begin
      set_d.keep[i] = en[i] && dec_i.allow[set_d.cand[i][3:0]] &&
                      ((set_d.cand[i] & dec_i.hi_mask) == '0);
    end
    set_d.count = dec_i.count;
  end

  // Advance when the serializer can take the set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      set_q <= set_d;
    end
  end

  assign valid_o = v_q;
  assign set_o   = set_q;

endmodule

`default_nettype wire

/* hw/rtl/bse_serialize.sv */
// Output stage of the expander: holds one candidate set and sends its kept
// successors one per cycle, lowest slot first, through a result register.
// Depends on bse_pkg.
`default_nettype none

module bse_serialize (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire bse_pkg::cset_t  set_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output bse_pkg::out_item_t   result_o
);

  logic [bse_pkg::NumCand-1:0] pend_d, pend_q;
  logic [bse_pkg::NumCand-1:0] low_bit, rest;
  bse_pkg::cset_t              set_q;
  logic                        out_v_q;
  bse_pkg::out_item_t          out_d, out_q;
  logic                        load;

  // Pick the lowest pending slot
  always_comb begin
    low_bit = pend_q & (~pend_q + 1'b1);
    rest    = pend_q & ~low_bit;
    ready_o = rest == '0;
    load    = valid_i && ready_o;
    pend_d  = load ? set_i.keep : rest;

    out_d.next_state = '0;
    for (int i = 0; i < int'(bse_pkg::NumCand); i++) begin
      out_d.next_state = out_d.next_state |
                         (set_q.cand[i] & {bse_pkg::StateW{low_bit[i]}});
    end
    out_d.next_count = set_q.count;
    out_d.last       = rest == '0;
  end

  // Hold the pending mask and the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      out_v_q <= |pend_q;
    end
  end

  // Load a new set and register the result
  always_ff @(posedge clk_i) begin
    if (load) begin
      set_q <= set_i;
    end
    out_q <= out_d;
  end

  assign valid_o  = out_v_q;
  assign result_o = out_q;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for border_state_expander.
// Drives border states through the command port, predicts the kept successors
// and checks each result transaction. Depends on bse_pkg and the block's RTL.
module tb_top;
  import bse_pkg::*;

  localparam int HalfPeriod  = 5;
  localparam int DrainCycles = 12;
  localparam int StallLimit  = 2000;
  localparam int GapPercent  = 24;
  localparam int MaxLen      = MaxWidthDef;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  in_item_t            item_in   = '0;
  logic                res_valid;
  out_item_t           res_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CfgBumpPos;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // Shadow copy of the configuration registers
  int unsigned model_bump = 0;
  int unsigned model_len  = MaxLen;

  in_item_t  pending_q[$];
  out_item_t successor_q[$];
  int        n_errors     = 0;
  int        stall_cycles = 0;
  bit        no_gaps      = 1'b0;

  always #HalfPeriod clk_i = ~clk_i;

  border_state_expander DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_in),
    .valid_o    (res_valid),
    .result_o   (res_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  // Build all successors of one state in emission order, keep the ones that
  // pass the type and stack-fit filter, and queue them as expected results
  function automatic void expand_successors(input in_item_t it);
    logic [StateW-1:0] s, stk, se, ndy, norm, znorm, cv, succ;
    logic [StateW-1:0] cands[$];
    logic [TypeW-1:0]  prev;
    logic              before_bump, at_bump;
    out_item_t         r;
    out_item_t         kept[$];
    int                k;
    s           = it.current_state;
    before_bump = model_bump != 0 && int'(it.position) == int'(model_bump) - 1;
    at_bump     = int'(it.position) == int'(model_bump);
    prev        = s[6] ? TEdge : s[TypeW-1:0];
    norm        = s & FNorm;
    ndy         = s & FNdyBump;
    stk         = s & StkMask;
    se          = before_bump ? FSetEdge : 64'd0;
    if (prev < TNeedy) cands.push_back(stk | se | ndy | norm | TEmpty);
    for (int col = 0; col < 2; col++) begin
      cv = col;
      // liberty stone of this color
      if (prev < TNeedy || prev[0] != cv[0]) begin
        cands.push_back(stk | ndy | (cv[0] ? 64'd0 : FNorm) | TLib | cv |
                        ((before_bump && (prev == TEmpty || prev == (TLib | cv[3:0])))
                         ? FSetEdge : 64'd0));
      end
      if (at_bump && col == 0) continue;
      if (at_bump) ndy = FNdyBump;
      // needy stone, plain and with a pushed link
      if (prev == TEdge || (prev != TEmpty && prev[0] != cv[0])) begin
        znorm = (it.position != 0) ? norm : (cv[0] ? FNorm : 64'd0);
        cands.push_back(stk | se | ndy | znorm | TNeedy | cv);
        cands.push_back((stk << 1) | (cv << StkShift) | ndy | znorm |
                        (TNeedy | THasR) | cv);
      end
      // needy stone that keeps or pops the top link; the edge flag chosen
      // here stays in force for the other color
      if (stk > (64'd1 << StkShift) && stk[StkShift] == cv[0] &&
          !(prev == TEmpty || prev == (TLib | cv[3:0]) ||
            (prev & (TNeedy | THasR | TColor)) == (TNeedy | cv[3:0]))) begin
        se = (before_bump && (prev & (TNeedy | THasR)) == (TNeedy | THasR))
             ? FSetEdge : 64'd0;
        cands.push_back(stk | se | ndy | norm | (TNeedy | THasL | THasR) | cv);
        cands.push_back(((stk >> 1) & StkMask) | se | ndy | norm | (TNeedy | THasL) | cv);
      end
    end
    // keep candidates whose type is allowed and whose stack fits the border
    k = StkShift + int'(model_len) - int'(it.position);
    foreach (cands[i]) begin
      succ = cands[i];
      if (it.allow_mask[succ[TypeW-1:0]] &&
          ((k <= 0) ? succ == 64'd0 : (k >= 64 || (succ >> k) == 64'd0))) begin
        r.next_state = succ;
        r.next_count = it.path_count;
        r.last       = 1'b0;
        kept.push_back(r);
      end
    end
    if (kept.size() != 0) kept[kept.size() - 1].last = 1'b1;
    foreach (kept[i]) successor_q.push_back(kept[i]);
  endfunction

  function automatic void queue_item(input logic [StateW-1:0] st,
                                     input logic [CountW-1:0] cnt,
                                     input logic [PosW-1:0] pos,
                                     input logic [MaskW-1:0] mask);
    in_item_t it;
    it.current_state = st;
    it.path_count    = cnt;
    it.position      = pos;
    it.allow_mask    = mask;
    pending_q.push_back(it);
  endfunction

  // Mostly well-formed states (sentinel-terminated link stack that about
  // fits), positions around the bump; the rest is unconstrained noise
  function automatic in_item_t rand_border_item();
    in_item_t          it;
    int                hi, depth;
    logic [StateW-1:0] links, flags;
    it.path_count = {$urandom, $urandom};
    if ($urandom_range(99) < 15) begin
      it.current_state = {$urandom, $urandom};
      it.position      = PosW'($urandom_range(31));
      it.allow_mask    = MaskW'($urandom);
    end else begin
      case ($urandom_range(3))
        0:       it.position = PosW'(model_bump);
        1:       it.position = PosW'((model_bump == 0) ? 0 : model_bump - 1);
        default: it.position = PosW'($urandom_range(MaxLen - 1));
      endcase
      hi    = int'(model_len) - int'(it.position);
      depth = (hi > 0) ? $urandom_range(hi) : 0;
      links = {$urandom, $urandom} & ((64'd1 << depth) - 64'd1);
      flags = '0;
      if ($urandom_range(7) == 0) flags |= FSetEdge;
      if ($urandom_range(1) != 0) flags |= FNorm;
      if ($urandom_range(1) != 0) flags |= FNdyBump;
      it.current_state = (64'h80 << depth) | (links << StkShift) | flags |
                         StateW'($urandom_range(15));
      case ($urandom_range(3))
        0, 1:    it.allow_mask = '1;
        2:       it.allow_mask = MaskW'($urandom) | MaskW'($urandom);
        default: it.allow_mask = MaskW'($urandom);
      endcase
    end
    return it;
  endfunction

  // Offer pending items; hold an offered transaction until the block takes it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      item_in <= '0;
    end else begin : drive
      bit took;
      bit offer;
      took = start && !busy;
      if (took) begin
        expand_successors(item_in);
        pending_q.delete(0);
      end
      offer = pending_q.size() != 0 && (no_gaps || $urandom_range(99) >= GapPercent);
      if (start && !took) begin
        start <= 1'b1;
      end else if (offer) begin
        start   <= 1'b1;
        item_in <= pending_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Compare each result transaction with the oldest expected successor
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && res_valid) begin
      if (successor_q.size() == 0) begin
        $error("unexpected result: next_state %h next_count %h last %b",
               res_item.next_state, res_item.next_count, res_item.last);
        n_errors++;
      end else begin
        want = successor_q.pop_front();
        if (res_item.next_state !== want.next_state) begin
          $error("next_state: expected %h, actual %h", want.next_state, res_item.next_state);
          n_errors++;
        end
        if (res_item.next_count !== want.next_count) begin
          $error("next_count: expected %h, actual %h", want.next_count, res_item.next_count);
          n_errors++;
        end
        if (res_item.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, res_item.last);
          n_errors++;
        end
      end
    end
  end

  // Count cycles without any transaction
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= StallLimit);
    $display("Verification failed");
    $finish;
  end

  // Wait until every item is taken and every successor has come out, then
  // let items without successors leave the pipeline
  task automatic wait_idle();
    while (pending_q.size() != 0 || successor_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgBumpPos) model_bump = val;
    else model_len = (val > MaxLen) ? MaxLen : val;
  endtask

  task automatic set_config(input int bump, input int len, input bit steady);
    wait_idle();
    write_reg(CfgBumpPos, CfgDataW'(bump));
    write_reg(CfgBorderLen, CfgDataW'(len));
    no_gaps = steady;
  endtask

  task automatic add_random(input int n);
    repeat (n) pending_q.push_back(rand_border_item());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: bump at column zero, full border length
    queue_item(64'h0, 64'h0, 5'd0, 16'hFFFF);
    queue_item(64'h80, '1, 5'd0, 16'hFFFF);
    queue_item(64'h81, 64'h1, 5'd3, 16'hFFFF);
    queue_item(64'h82, 64'h2, 5'd3, 16'hFFFF);
    queue_item(64'h83, 64'h3, 5'd3, 16'hFFFF);
    queue_item(64'h188, 64'h4, 5'd2, 16'hFFFF);
    queue_item(64'h109, 64'h5, 5'd2, 16'hFFFF);
    queue_item(64'h18C, 64'h6, 5'd6, 16'hFFFF);
    queue_item(64'h10D, 64'h7, 5'd6, 16'hFFFF);
    queue_item(64'h1AE, 64'h8, 5'd1, 16'hFFFF);
    queue_item(64'h19F, 64'h9, 5'd4, 16'hFFFF);
    queue_item(64'hC4, 64'hA, 5'd2, 16'hFFFF);
    queue_item('1, 64'h8000_0000_0000_0000, 5'd31, 16'hFFFF);
    // link push past bit 63
    queue_item(64'h8000_0000_0000_0180, 64'h5555_5555_5555_5555, 5'd0, 16'hFFFF);
    // nothing kept
    queue_item(64'h81, 64'hB, 5'd5, 16'h0000);
    queue_item(64'h80, 64'hC, 5'd20, 16'hFFFF);
    queue_item(64'h80, 64'hD, 5'd28, 16'hFFFF);
    queue_item(64'h86, 64'hE, 5'd7, 16'h0104);
    queue_item(64'h3F85, 64'hAAAA_AAAA_AAAA_AAAA, 5'd10, 16'hAAAA);
    add_random(40);

    // Bump inside the border; black closing pair sets the edge flag that the
    // white needy pair then reuses
    set_config(5, 21, 1'b0);
    queue_item(64'h10C, 64'h11, 5'd4, 16'hFFFF);
    queue_item(64'h81, 64'h12, 5'd4, 16'hFFFF);
    queue_item(64'h82, 64'h13, 5'd5, 16'hFFFF);
    add_random(50);

    // Column zero just before the bump
    set_config(1, 21, 1'b0);
    queue_item(64'h180, 64'h14, 5'd0, 16'hFFFF);
    add_random(50);

    // Back-to-back items with no sender gaps
    set_config(20, 12, 1'b1);
    add_random(50);

    // Both registers at their top code; border length saturates
    set_config(31, 31, 1'b0);
    add_random(50);

    set_config(0, 0, 1'b0);
    add_random(40);

    set_config(21, 1, 1'b0);
    add_random(40);

    set_config(12, 16, 1'b0);
    add_random(50);

    set_config(3, 21, 1'b0);
    add_random(50);

    wait_idle();
    if (n_errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
